FILE: rtl/spc2d_pkg.sv
package spc2d_pkg;

   localparam logic OP_COEF = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic [1:0] REG_IMAGE = 2'd0;
   localparam logic [1:0] REG_KERNEL = 2'd1;
   localparam logic [1:0] REG_PAD = 2'd2;
   localparam logic [1:0] REG_STEP = 2'd3;

   localparam int SUM_WIDTH = 38;
   localparam int POS_WIDTH = 7;

   typedef struct packed {
      logic [POS_WIDTH-1:0] out_row;
      logic [POS_WIDTH-1:0] out_col;
      logic                 last;
   } tag_type;

endpackage

FILE: rtl/spc2d_front.sv
module spc2d_front #(
   parameter int MAX_IMAGE = 64,
   parameter int MAX_KERNEL = 7,
   parameter int MAX_PAD = 3,
   parameter int PIXEL_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [6:0]                    csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [5:0]                    req_coef_index,
   input  logic signed [PIXEL_WIDTH-1:0] req_value,
   output logic                          q_valid,
   input  logic                          q_ready,
   output logic signed [PIXEL_WIDTH-1:0] q_pixel,
   output logic                          q_fire,
   output logic [$clog2(MAX_IMAGE+2*MAX_PAD)-1:0] q_col,
   output logic [$clog2(MAX_KERNEL)-1:0] q_slot,
   output spc2d_pkg::tag_type            q_tag,
   output logic [3:0]                    k_eff,
   output logic                          coef_we,
   output logic [$clog2(MAX_KERNEL*MAX_KERNEL+1)-1:0] coef_addr,
   output logic signed [PIXEL_WIDTH-1:0] coef_data
);
   localparam int SIDE = MAX_IMAGE + 2 * MAX_PAD;
   localparam int CW = $clog2(SIDE);
   localparam int SW = $clog2(MAX_KERNEL);
   localparam int NC = MAX_KERNEL * MAX_KERNEL;
   localparam int AW = $clog2(NC + 1);

   logic [6:0] image_ff, image_in;
   logic [2:0] kernel_ff, kernel_in;
   logic [1:0] pad_ff, pad_in;
   logic [2:0] step_ff, step_in;
   logic [CW-1:0] row_ff, row_in, col_ff, col_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [2:0] rmod_ff, rmod_in, cmod_ff, cmod_in;
   logic [6:0] orow_ff, orow_in, ocol_ff, ocol_in;

   logic [7:0] n, side, m, p;
   logic [2:0] s;
   logic take_pix, rdone, cdone, border;
   logic [7:0] r8, c8;

   always_comb begin
      n = (image_ff == 7'd0) ? 8'd1 : ((32'(image_ff) > MAX_IMAGE) ? 8'(MAX_IMAGE) : 8'(image_ff));
      m = (kernel_ff == 3'd0) ? 8'd1 :
          ((32'(kernel_ff) > MAX_KERNEL) ? 8'(MAX_KERNEL) : 8'(kernel_ff));
      p = (32'(pad_ff) > MAX_PAD) ? 8'(MAX_PAD) : 8'(pad_ff);
      s = (step_ff == 3'd0) ? 3'd1 : step_ff;
      side = n + (p << 1);
      r8 = 8'(row_ff);
      c8 = 8'(col_ff);
   end

   assign csr_ready = 1'b1;
   assign req_ready = !req_valid || req_opcode == spc2d_pkg::OP_COEF || q_ready;
   assign take_pix = req_valid && req_ready && req_opcode == spc2d_pkg::OP_PIXEL;
   assign rdone = (r8 + 8'd1 >= m);
   assign cdone = (c8 + 8'd1 >= m);
   assign border = r8 < p || c8 < p || r8 >= p + n || c8 >= p + n;

   assign q_valid = take_pix;
   assign q_pixel = border ? '0 : req_value;
   assign q_col = col_ff;
   assign q_slot = slot_ff;
   assign q_fire = rdone && cdone && rmod_ff == 3'd0 && cmod_ff == 3'd0;
   assign q_tag.out_row = orow_ff;
   assign q_tag.out_col = ocol_ff;
   // A window on the stride grid is the last one when no further step fits.
   assign q_tag.last = (r8 + 8'd1 + 8'(s) > side) && (c8 + 8'd1 + 8'(s) > side);
   assign k_eff = 4'(m);
   assign coef_we = req_valid && req_ready && req_opcode == spc2d_pkg::OP_COEF
                    && 32'(req_coef_index) < NC;
   assign coef_addr = AW'(req_coef_index);
   assign coef_data = req_value;

   always_comb begin
      image_in = image_ff;
      kernel_in = kernel_ff;
      pad_in = pad_ff;
      step_in = step_ff;
      row_in = row_ff;
      col_in = col_ff;
      slot_in = slot_ff;
      rmod_in = rmod_ff;
      cmod_in = cmod_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      if (csr_valid) begin
         unique case (csr_index)
            spc2d_pkg::REG_IMAGE: image_in = csr_data;
            spc2d_pkg::REG_KERNEL: kernel_in = csr_data[2:0];
            spc2d_pkg::REG_PAD: pad_in = csr_data[1:0];
            default: step_in = csr_data[2:0];
         endcase
         row_in = '0;
         col_in = '0;
         slot_in = '0;
         rmod_in = '0;
         cmod_in = '0;
         orow_in = '0;
         ocol_in = '0;
      end else if (take_pix) begin
         if (cdone) begin
            cmod_in = (cmod_ff + 3'd1 == s) ? 3'd0 : cmod_ff + 3'd1;
            if (cmod_ff == 3'd0) ocol_in = ocol_ff + 7'd1;
         end
         if (c8 + 8'd1 >= side) begin
            col_in = '0;
            cmod_in = '0;
            ocol_in = '0;
            if (rdone) begin
               rmod_in = (rmod_ff + 3'd1 == s) ? 3'd0 : rmod_ff + 3'd1;
               if (rmod_ff == 3'd0) orow_in = orow_ff + 7'd1;
            end
            slot_in = (32'(slot_ff) == MAX_KERNEL - 1) ? '0 : slot_ff + SW'(1);
            if (r8 + 8'd1 >= side) begin
               row_in = '0;
               slot_in = '0;
               rmod_in = '0;
               orow_in = '0;
            end else begin
               row_in = row_ff + CW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_ff <= 7'd64;
         kernel_ff <= 3'd3;
         pad_ff <= 2'd0;
         step_ff <= 3'd1;
         row_ff <= '0;
         col_ff <= '0;
         slot_ff <= '0;
         rmod_ff <= '0;
         cmod_ff <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
      end else begin
         image_ff <= image_in;
         kernel_ff <= kernel_in;
         pad_ff <= pad_in;
         step_ff <= step_in;
         row_ff <= row_in;
         col_ff <= col_in;
         slot_ff <= slot_in;
         rmod_ff <= rmod_in;
         cmod_ff <= cmod_in;
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) q_valid |-> !coef_we)
      else $error("Pixel and coefficient beat taken together.");
   assert property (@(posedge clock) disable iff (reset)
      take_pix && !csr_valid && 8'(col_ff) + 8'd1 < side |=> col_ff == $past(col_ff) + CW'(1))
      else $error("Column did not advance.");
   assert property (@(posedge clock) disable iff (reset) 32'(slot_ff) < MAX_KERNEL)
      else $error("Line slot out of range.");
endmodule

FILE: rtl/spc2d_back.sv
module spc2d_back #(
   parameter int MAX_IMAGE = 64,
   parameter int MAX_KERNEL = 7,
   parameter int MAX_PAD = 3,
   parameter int PIXEL_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  logic signed [PIXEL_WIDTH-1:0] q_pixel,
   input  logic                          q_fire,
   input  logic [$clog2(MAX_IMAGE+2*MAX_PAD)-1:0] q_col,
   input  logic [$clog2(MAX_KERNEL)-1:0] q_slot,
   input  spc2d_pkg::tag_type            q_tag,
   input  logic [3:0]                    k_eff,
   input  logic                          coef_we,
   input  logic [$clog2(MAX_KERNEL*MAX_KERNEL+1)-1:0] coef_addr,
   input  logic signed [PIXEL_WIDTH-1:0] coef_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [spc2d_pkg::SUM_WIDTH-1:0] rsp_sum,
   output logic [6:0]                    rsp_out_row,
   output logic [6:0]                    rsp_out_col,
   output logic                          rsp_last
);
   localparam int SIDE = MAX_IMAGE + 2 * MAX_PAD;
   localparam int K = MAX_KERNEL;
   localparam int NC = K * K;
   localparam int SW = $clog2(K);
   localparam int CIW = $clog2(NC);
   localparam int PW = 2 * PIXEL_WIDTH;
   localparam int SUMW = spc2d_pkg::SUM_WIDTH;
   localparam int DEPTH = 5;
   localparam int FW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   // Window: K rows by K columns shift register; the newest column is at index K-1.
   logic signed [PIXEL_WIDTH-1:0] win_ff [K][K];
   logic signed [PIXEL_WIDTH-1:0] coef_ff [NC];
   logic signed [PIXEL_WIDTH-1:0] line_mem [K][SIDE];

   // The pipeline never stalls; results collect in a short queue whose space is reserved
   // when a window-completing beat is taken.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_fire_ff;
   spc2d_pkg::tag_type s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic [SW-1:0] s1_slot_ff;
   logic signed [PIXEL_WIDTH-1:0] s1_pix_ff;
   logic signed [PIXEL_WIDTH-1:0] rd_ff [K];
   logic signed [PW-1:0] prod_ff [K][K];
   logic signed [SUMW-1:0] part_ff [K];
   logic [CNTW-1:0] cnt_ff;
   logic signed [SUMW-1:0] fifo_sum_ff [DEPTH];
   spc2d_pkg::tag_type fifo_tag_ff [DEPTH];
   logic [FW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNTW-1:0] fill_ff;
   logic rsp_take;

   assign q_ready = 32'(cnt_ff) < DEPTH;
   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (coef_we) coef_ff[coef_addr[$clog2(NC)-1:0]] <= coef_data;
      if (reset) begin
         for (int i = 0; i < NC; i++) coef_ff[i] <= '0;
      end
   end

   // Stage 1: read column of stored rows, write new pixel.
   always_ff @(posedge clock) begin
      if (q_valid) begin
         line_mem[q_slot][q_col] <= q_pixel;
         for (int a = 0; a < K; a++) rd_ff[a] <= line_mem[a][q_col];
      end
      s1_pix_ff <= q_pixel;
      s1_slot_ff <= q_slot;
      s1_fire_ff <= q_fire;
      s1_tag_ff <= q_tag;
   end

   // Stage 2: shift the window and form the window of products.
   logic signed [PIXEL_WIDTH-1:0] col_v [K];
   logic signed [PIXEL_WIDTH-1:0] tap [K][K];
   always_comb begin
      for (int a = 0; a < K; a++) col_v[a] = rd_ff[a];
      col_v[s1_slot_ff] = s1_pix_ff;
      for (int a = 0; a < K; a++) begin
         for (int b = 0; b < K - 1; b++) tap[a][b] = win_ff[a][b+1];
         tap[a][K-1] = col_v[a];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int a = 0; a < K; a++)
            for (int b = 0; b < K; b++) win_ff[a][b] <= tap[a][b];
      end
   end

   // Row a of the window is slot (slot + 1 + a + K - k) mod K when k rows are used.
   logic [SW:0] base;
   always_comb begin
      base = (SW+1)'(s1_slot_ff) + (SW+1)'(1) + (SW+1)'(K) - (SW+1)'(k_eff);
      if (32'(base) >= K) base = base - (SW+1)'(K);
   end

   logic [SW:0] rsel [K];
   always_comb begin
      for (int a = 0; a < K; a++) begin
         rsel[a] = base + (SW+1)'(a);
         if (32'(rsel[a]) >= K) rsel[a] = rsel[a] - (SW+1)'(K);
      end
   end

   logic signed [PIXEL_WIDTH-1:0] px_sel [K][K];
   logic signed [PIXEL_WIDTH-1:0] cf_sel [K][K];
   always_comb begin
      for (int a = 0; a < K; a++)
         for (int b = 0; b < K; b++) begin
            px_sel[a][b] = '0;
            cf_sel[a][b] = '0;
            if (a < 32'(k_eff) && b < 32'(k_eff)) begin
               px_sel[a][b] = tap[rsel[a][SW-1:0]][SW'(K - 32'(k_eff) + b)];
               cf_sel[a][b] = coef_ff[CIW'(a * 32'(k_eff) + b)];
            end
         end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < K; a++)
         for (int b = 0; b < K; b++)
            prod_ff[a][b] <= PW'(px_sel[a][b]) * PW'(cf_sel[a][b]);
      s2_tag_ff <= s1_tag_ff;
   end

   // Stage 3: sum each window row.
   logic signed [SUMW-1:0] row_sum [K];
   always_comb begin
      for (int a = 0; a < K; a++) begin
         row_sum[a] = '0;
         for (int b = 0; b < K; b++) row_sum[a] = row_sum[a] + SUMW'(prod_ff[a][b]);
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < K; a++) part_ff[a] <= row_sum[a];
      s3_tag_ff <= s2_tag_ff;
   end

   // Stage 4: add the row sums into the result queue.
   logic signed [SUMW-1:0] total;
   always_comb begin
      total = '0;
      for (int a = 0; a < K; a++) total = total + part_ff[a];
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         fifo_sum_ff[wr_ptr_ff] <= total;
         fifo_tag_ff[wr_ptr_ff] <= s3_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         cnt_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         s1_valid_ff <= q_valid;
         s2_valid_ff <= s1_valid_ff && s1_fire_ff;
         s3_valid_ff <= s2_valid_ff;
         cnt_ff <= cnt_ff + CNTW'(q_valid && q_fire) - CNTW'(rsp_take);
         if (s3_valid_ff)
            wr_ptr_ff <= (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + FW'(1);
         if (rsp_take)
            rd_ptr_ff <= (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + FW'(1);
         fill_ff <= fill_ff + CNTW'(s3_valid_ff) - CNTW'(rsp_take);
      end
   end

   assign rsp_valid = fill_ff != '0;
   assign rsp_sum = fifo_sum_ff[rd_ptr_ff];
   assign rsp_out_row = fifo_tag_ff[rd_ptr_ff].out_row;
   assign rsp_out_col = fifo_tag_ff[rd_ptr_ff].out_col;
   assign rsp_last = fifo_tag_ff[rd_ptr_ff].last;

   assert property (@(posedge clock) disable iff (reset) 32'(cnt_ff) <= DEPTH)
      else $error("Result count overflow.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum))
      else $error("Result beat dropped.");
   assert property (@(posedge clock) disable iff (reset) fill_ff <= cnt_ff)
      else $error("Result queue holds more than was reserved.");
   assert property (@(posedge clock) disable iff (reset) s3_valid_ff |-> 32'(fill_ff) < DEPTH)
      else $error("Result queue overflow.");
endmodule

FILE: rtl/strided_padded_conv2d.sv
// A pixel beat that completes a window raises rsp_valid once it has passed the row-buffer read,
// the multiplier array, the row adders and the write of the summed total into the result queue.
// Throughput: one beat per cycle; up to five results may be outstanding before input stalls.
// Reset is synchronous and active high: registers return to their defaults, coefficients clear.
// The row buffer holds no reset value and is meaningful only once rows were streamed.
module strided_padded_conv2d #(
   parameter int MAX_IMAGE = 64,
   parameter int MAX_KERNEL = 7,
   parameter int MAX_PAD = 3,
   parameter int PIXEL_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [6:0]                    csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [5:0]                    req_coef_index,
   input  logic signed [PIXEL_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [37:0]            rsp_sum,
   output logic [6:0]                    rsp_out_row,
   output logic [6:0]                    rsp_out_col,
   output logic                          rsp_last
);
   logic q_valid, q_ready, q_fire, coef_we;
   logic signed [PIXEL_WIDTH-1:0] q_pixel, coef_data;
   logic [$clog2(MAX_IMAGE+2*MAX_PAD)-1:0] q_col;
   logic [$clog2(MAX_KERNEL)-1:0] q_slot;
   spc2d_pkg::tag_type q_tag;
   logic [3:0] k_eff;
   logic [$clog2(MAX_KERNEL*MAX_KERNEL+1)-1:0] coef_addr;

   spc2d_front #(.MAX_IMAGE(MAX_IMAGE), .MAX_KERNEL(MAX_KERNEL), .MAX_PAD(MAX_PAD),
      .PIXEL_WIDTH(PIXEL_WIDTH)) u_front (.*);
   spc2d_back #(.MAX_IMAGE(MAX_IMAGE), .MAX_KERNEL(MAX_KERNEL), .MAX_PAD(MAX_PAD),
      .PIXEL_WIDTH(PIXEL_WIDTH)) u_back (.*);
endmodule
